/* hw/rtl/sm4_pkg.sv */
// Shared types, constants and round functions of the SM4 engine.
`default_nettype none
package sm4_pkg;

	localparam int ROUNDS_DEF = 32;

	localparam logic [31:0] FK0 = 32'ha3b1bac6;
	localparam logic [31:0] FK1 = 32'h56aa3350;
	localparam logic [31:0] FK2 = 32'h677d9197;
	localparam logic [31:0] FK3 = 32'hb27022dc;

	localparam logic [1:0] MODE_ECB = 2'd0;
	localparam logic [1:0] MODE_CBC = 2'd1;
	localparam logic [1:0] MODE_CTR = 2'd2;

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_KEY_HIGH   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEY_LOW    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_IV_HIGH    = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_IV_LOW     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CHAIN_MODE = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_DECRYPT    = 3'd5;

	localparam logic [7:0] SBOX [0:255] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	typedef struct packed {
		logic accept;
		logic kx_step;
		logic rnd_step;
		logic finish;
	} sm4_cmd_t;

	function automatic logic [31:0] tau(input logic [31:0] x);
		return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
	endfunction

	function automatic logic [31:0] lin_enc(input logic [31:0] b);
		return b ^ {b[29:0], b[31:30]} ^ {b[21:0], b[31:22]} ^ {b[13:0], b[31:14]}
			^ {b[7:0], b[31:8]};
	endfunction

	function automatic logic [31:0] lin_key(input logic [31:0] b);
		return b ^ {b[18:0], b[31:19]} ^ {b[8:0], b[31:9]};
	endfunction

	function automatic logic [31:0] ck_word(input logic [5:0] i);
		logic [31:0] w;
		logic [7:0] pos;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			pos = 8'({i, 2'b00}) + 8'(j);
			w = {w[23:0], 8'(pos * 8'd7)};
		end
		return w;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/sm4_cipher_ecb_cbc_ctr_top.sv */
// Top level of the SM4 block cipher engine with ECB, CBC and CTR chaining.
// An item is one 128-bit block. Without first_block it runs the load, 32 rounds at one
// round a cycle in the shared round unit, and a finish step that chains and registers the
// result once no earlier result is held; an item with first_block set first runs the
// 32-step key schedule through the same sequencer. One item is in work at a time; the next
// is taken as soon as the result is registered, even while it waits.
// Key and IV take effect at the next first block, and the round-key order is fixed then;
// the chaining mode and the CBC direction follow the registers on every item.
`default_nettype none
module sm4_cipher_ecb_cbc_ctr_top #(
	parameter int ROUNDS = sm4_pkg::ROUNDS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [63:0]                    data_high,
	input  wire logic [63:0]                    data_low,
	input  wire logic                           first_block,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [63:0]                         result_high,
	output logic [63:0]                         result_low,
	input  wire logic                           wr_en,
	input  wire logic [sm4_pkg::REG_IDX_W-1:0]  wr_index,
	input  wire logic [63:0]                    wr_data
);

	localparam int CW = $clog2(ROUNDS);

	sm4_pkg::sm4_cmd_t cmd;
	logic [CW-1:0] idx;

	sm4_ctrl #(.ROUNDS(ROUNDS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.first_block(first_block),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd(cmd),
		.idx(idx)
	);

	sm4_dp #(.ROUNDS(ROUNDS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.idx(idx),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.data_high(data_high),
		.data_low(data_low),
		.first_block(first_block),
		.result_high(result_high),
		.result_low(result_low)
	);

endmodule
`default_nettype wire

/* hw/rtl/sm4_ctrl.sv */
// Sequencing state machine of the SM4 engine: key schedule, rounds and output handshake.
`default_nettype none
module sm4_ctrl #(
	parameter int ROUNDS = sm4_pkg::ROUNDS_DEF,
	localparam int CW = $clog2(ROUNDS)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             first_block,
	output logic                  in_stall,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output sm4_pkg::sm4_cmd_t     cmd,
	output logic [CW-1:0]         idx
);

	localparam logic [CW-1:0] LAST = CW'(ROUNDS - 1);

	typedef enum logic [3:0] {
		IDLE = 4'b0001,
		KEYX = 4'b0010,
		RUND = 4'b0100,
		FIN  = 4'b1000
	} state_t;

	state_t state_q;
	logic [CW-1:0] cnt_q;
	logic out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			IDLE: cmd.accept = in_valid;
			KEYX: cmd.kx_step = 1'b1;
			RUND: cmd.rnd_step = 1'b1;
			FIN: cmd.finish = !out_valid_q || !out_stall;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && !cmd.finish)
				out_valid_q <= 1'b0;
			case (state_q)
				IDLE: begin
					if (in_valid) begin
						cnt_q <= '0;
						state_q <= first_block ? KEYX : RUND;
					end
				end
				KEYX: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST)
						state_q <= RUND;
				end
				RUND: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == LAST)
						state_q <= FIN;
				end
				FIN: begin
					if (cmd.finish) begin
						out_valid_q <= 1'b1;
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign in_stall = (state_q != IDLE);
	assign out_valid = out_valid_q;
	assign idx = cnt_q;

`ifndef SYNTH
	a_first_to_keyx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == IDLE && in_valid && first_block) |=> (state_q == KEYX && cnt_q == '0))
		else $error("first item did not start key schedule");
	a_keyx_to_rund: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == KEYX && cnt_q == LAST) |=> (state_q == RUND && cnt_q == '0))
		else $error("rounds did not start at zero after key schedule");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_valid_q && out_stall))
		else $error("result overwritten while held");
	a_valid_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == FIN))
		else $error("result raised outside finish");
`endif

endmodule
`default_nettype wire

/* hw/rtl/sm4_dp.sv */
// SM4 datapath: configuration, key schedule, round-key store, round unit and chaining.
`default_nettype none
module sm4_dp #(
	parameter int ROUNDS = sm4_pkg::ROUNDS_DEF,
	localparam int CW = $clog2(ROUNDS)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire sm4_pkg::sm4_cmd_t               cmd,
	input  wire logic [CW-1:0]                   idx,
	input  wire logic                            wr_en,
	input  wire logic [sm4_pkg::REG_IDX_W-1:0]   wr_index,
	input  wire logic [63:0]                     wr_data,
	input  wire logic [63:0]                     data_high,
	input  wire logic [63:0]                     data_low,
	input  wire logic                            first_block,
	output logic [63:0]                          result_high,
	output logic [63:0]                          result_low
);

	logic [63:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic [1:0] mode_q;
	logic dec_q;
	logic [127:0] chain_q;

	logic [31:0] kw_q [0:3];
	logic [31:0] rk_q [0:ROUNDS-1];
	logic [31:0] x_q [0:3];
	logic [127:0] din_q;
	logic [127:0] res_q;

	logic [127:0] din, iv, chain_sel, x_init, cblk, res_d, chain_d;
	logic [31:0] kx_new, rnd_new;
	logic [CW-1:0] rk_widx;

	assign din = {data_high, data_low};
	assign iv = {iv_high_q, iv_low_q};
	assign chain_sel = first_block ? iv : chain_q;

	always_comb begin
		case (mode_q)
			sm4_pkg::MODE_CBC: x_init = dec_q ? din : (din ^ chain_sel);
			sm4_pkg::MODE_CTR: x_init = chain_sel;
			default: x_init = din;
		endcase
	end

	assign kx_new = kw_q[0] ^ sm4_pkg::lin_key(sm4_pkg::tau(kw_q[1] ^ kw_q[2] ^ kw_q[3]
		^ sm4_pkg::ck_word(6'(idx))));
	assign rk_widx = dec_q ? (CW'(ROUNDS - 1) - idx) : idx;
	assign rnd_new = x_q[0] ^ sm4_pkg::lin_enc(sm4_pkg::tau(x_q[1] ^ x_q[2] ^ x_q[3]
		^ rk_q[idx]));
	assign cblk = {x_q[3], x_q[2], x_q[1], x_q[0]};

	always_comb begin
		res_d = cblk;
		chain_d = chain_q;
		case (mode_q)
			sm4_pkg::MODE_CBC: begin
				if (dec_q) begin
					res_d = cblk ^ chain_q;
					chain_d = din_q;
				end else begin
					chain_d = cblk;
				end
			end
			sm4_pkg::MODE_CTR: begin
				res_d = cblk ^ din_q;
				chain_d = chain_q + 128'd1;
			end
			default: chain_d = chain_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			iv_high_q <= '0;
			iv_low_q <= '0;
			mode_q <= sm4_pkg::MODE_ECB;
			dec_q <= 1'b0;
			chain_q <= '0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					sm4_pkg::REG_KEY_HIGH: key_high_q <= wr_data;
					sm4_pkg::REG_KEY_LOW: key_low_q <= wr_data;
					sm4_pkg::REG_IV_HIGH: iv_high_q <= wr_data;
					sm4_pkg::REG_IV_LOW: iv_low_q <= wr_data;
					sm4_pkg::REG_CHAIN_MODE: mode_q <= wr_data[1:0];
					sm4_pkg::REG_DECRYPT: dec_q <= wr_data[0];
					default: ;
				endcase
			end
			if (cmd.accept)
				chain_q <= chain_sel;
			else if (cmd.finish)
				chain_q <= chain_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			din_q <= din;
			{x_q[0], x_q[1], x_q[2], x_q[3]} <= x_init;
			if (first_block) begin
				kw_q[0] <= key_high_q[63:32] ^ sm4_pkg::FK0;
				kw_q[1] <= key_high_q[31:0] ^ sm4_pkg::FK1;
				kw_q[2] <= key_low_q[63:32] ^ sm4_pkg::FK2;
				kw_q[3] <= key_low_q[31:0] ^ sm4_pkg::FK3;
			end
		end
		if (cmd.kx_step) begin
			kw_q[0] <= kw_q[1];
			kw_q[1] <= kw_q[2];
			kw_q[2] <= kw_q[3];
			kw_q[3] <= kx_new;
			rk_q[rk_widx] <= kx_new;
		end
		if (cmd.rnd_step) begin
			x_q[0] <= x_q[1];
			x_q[1] <= x_q[2];
			x_q[2] <= x_q[3];
			x_q[3] <= rnd_new;
		end
		if (cmd.finish)
			res_q <= res_d;
	end

	assign result_high = res_q[127:64];
	assign result_low = res_q[63:0];

endmodule
`default_nettype wire

/* sim/sm4_cipher_ecb_cbc_ctr_top_tb.sv */
// Self-checking testbench for the SM4 ECB/CBC/CTR engine: directed table, then random messages.
`timescale 1ns / 1ps
module sm4_cipher_ecb_cbc_ctr_top_tb;

	localparam int NROUNDS = sm4_pkg::ROUNDS_DEF;
	localparam int IW = sm4_pkg::REG_IDX_W;
	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam logic [IW-1:0] REG_SPARE_A = 3'd6;
	localparam logic [IW-1:0] REG_SPARE_B = 3'd7;
	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 80;
	localparam longint LIMIT_NS = 64'd6_000_000;
	localparam logic [63:0] ONES = 64'hffff_ffff_ffff_ffff;
	localparam logic [63:0] STD_HI = 64'h0123_4567_89ab_cdef;
	localparam logic [63:0] STD_LO = 64'hfedc_ba98_7654_3210;

	typedef enum logic {ROW_WRITE, ROW_BLOCK} row_kind_t;
	typedef struct {
		row_kind_t kind;
		logic [IW-1:0] idx;
		logic [63:0] wdata;
		logic [63:0] dh;
		logic [63:0] dl;
		logic fb;
		bit fixed;
		logic [63:0] eh;
		logic [63:0] el;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [63:0] data_high;
	logic [63:0] data_low;
	logic first_block;
	logic out_valid;
	logic out_stall;
	logic [63:0] result_high;
	logic [63:0] result_low;
	logic wr_en;
	logic [IW-1:0] wr_index;
	logic [63:0] wr_data;

	// cipher state as the block should hold it
	logic [63:0] cfg_key_hi, cfg_key_lo, cfg_iv_hi, cfg_iv_lo;
	logic [1:0] cfg_mode;
	logic cfg_dec;
	logic [31:0] round_keys [NROUNDS];
	logic [127:0] chain_block;
	bit keys_loaded;

	logic [127:0] result_queue [$];
	stim_row_t directed_rows [$];

	int err_cnt = 0;
	int blocks_sent = 0;
	int results_seen = 0;
	int writes_done = 0;
	int holds_done = 0;
	bit hold_req = 0;
	bit calm = 0;

	sm4_cipher_ecb_cbc_ctr_top u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.data_high   (data_high),
		.data_low    (data_low),
		.first_block (first_block),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result_high (result_high),
		.result_low  (result_low),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#(LIMIT_NS);
		$display("sm4_cipher_ecb_cbc_ctr_top_tb failed");
		$finish;
	end

	function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [31:0] sbox_word(input logic [31:0] x);
		return {sm4_pkg::SBOX[x[31:24]], sm4_pkg::SBOX[x[23:16]], sm4_pkg::SBOX[x[15:8]],
			sm4_pkg::SBOX[x[7:0]]};
	endfunction

	function automatic logic [31:0] ck_const(input int i);
		logic [31:0] w;
		logic [7:0] b;
		w = '0;
		for (int j = 0; j < 4; j++) begin
			b = 8'((4 * i + j) * 7);
			w = {w[23:0], b};
		end
		return w;
	endfunction

	task automatic load_round_keys();
		logic [31:0] k [NROUNDS + 4];
		logic [31:0] t;
		k[0] = cfg_key_hi[63:32] ^ sm4_pkg::FK0;
		k[1] = cfg_key_hi[31:0] ^ sm4_pkg::FK1;
		k[2] = cfg_key_lo[63:32] ^ sm4_pkg::FK2;
		k[3] = cfg_key_lo[31:0] ^ sm4_pkg::FK3;
		for (int i = 0; i < NROUNDS; i++) begin
			t = sbox_word(k[i + 1] ^ k[i + 2] ^ k[i + 3] ^ ck_const(i));
			k[i + 4] = k[i] ^ t ^ rotl(t, 13) ^ rotl(t, 23);
		end
		for (int i = 0; i < NROUNDS; i++)
			round_keys[i] = cfg_dec ? k[NROUNDS + 3 - i] : k[i + 4];
	endtask

	function automatic logic [127:0] sm4_encipher(input logic [127:0] blk);
		logic [31:0] x0, x1, x2, x3, t, n;
		{x0, x1, x2, x3} = blk;
		for (int i = 0; i < NROUNDS; i++) begin
			t = sbox_word(x1 ^ x2 ^ x3 ^ round_keys[i]);
			n = x0 ^ t ^ rotl(t, 2) ^ rotl(t, 10) ^ rotl(t, 18) ^ rotl(t, 24);
			x0 = x1;
			x1 = x2;
			x2 = x3;
			x3 = n;
		end
		return {x3, x2, x1, x0};
	endfunction

	task automatic predict_block(input logic [127:0] din, input logic fb,
			output logic [127:0] res);
		if (fb) begin
			load_round_keys();
			chain_block = {cfg_iv_hi, cfg_iv_lo};
			keys_loaded = 1;
		end
		case (cfg_mode)
			sm4_pkg::MODE_CBC: begin
				if (cfg_dec) begin
					res = sm4_encipher(din) ^ chain_block;
					chain_block = din;
				end else begin
					res = sm4_encipher(din ^ chain_block);
					chain_block = res;
				end
			end
			sm4_pkg::MODE_CTR: begin
				res = sm4_encipher(chain_block) ^ din;
				chain_block = chain_block + 128'd1;
			end
			default: res = sm4_encipher(din);
		endcase
	endtask

	task automatic drive_idle(input int n);
		repeat (n) begin
			@(negedge clk);
			in_valid <= 1'b0;
			wr_en <= 1'b0;
		end
	endtask

	task automatic wait_idle();
		do drive_idle(1); while (result_queue.size() != 0);
		drive_idle(2);
	endtask

	task automatic write_reg(input logic [IW-1:0] idx, input logic [63:0] val);
		@(negedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		case (idx)
			sm4_pkg::REG_KEY_HIGH:   cfg_key_hi = val;
			sm4_pkg::REG_KEY_LOW:    cfg_key_lo = val;
			sm4_pkg::REG_IV_HIGH:    cfg_iv_hi = val;
			sm4_pkg::REG_IV_LOW:     cfg_iv_lo = val;
			sm4_pkg::REG_CHAIN_MODE: cfg_mode = val[1:0];
			sm4_pkg::REG_DECRYPT:    cfg_dec = val[0];
			default: ;
		endcase
		writes_done++;
	endtask

	task automatic send_block(input logic [63:0] dh, input logic [63:0] dl, input logic fb,
			input bit fixed, input logic [63:0] eh, input logic [63:0] el);
		logic [127:0] res;
		@(negedge clk);
		in_valid <= 1'b1;
		data_high <= dh;
		data_low <= dl;
		first_block <= fb;
		wr_en <= 1'b0;
		do @(posedge clk); while (in_stall);
		predict_block({dh, dl}, fb, res);
		result_queue.push_back(fixed ? {eh, el} : res);
		blocks_sent++;
	endtask

	function automatic void wr_row(input logic [IW-1:0] idx, input logic [63:0] val);
		directed_rows.push_back('{ROW_WRITE, idx, val, 64'd0, 64'd0, 1'b0, 1'b0, 64'd0, 64'd0});
	endfunction

	function automatic void blk_row(input logic [63:0] dh, input logic [63:0] dl,
			input logic fb, input bit fixed = 0, input logic [63:0] eh = 0,
			input logic [63:0] el = 0);
		directed_rows.push_back('{ROW_BLOCK, sm4_pkg::REG_KEY_HIGH, 64'd0, dh, dl, fb, fixed,
			eh, el});
	endfunction

	function automatic logic [63:0] pick_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return ONES;
			2: return ONES - 64'($urandom_range(1, 3));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	function automatic logic [63:0] pick_reg_value(input logic [IW-1:0] idx);
		logic [63:0] val;
		val = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
		case (idx)
			sm4_pkg::REG_CHAIN_MODE: val[1:0] = ($urandom_range(0, 6) == 6) ? MODE_SPARE :
				2'($urandom_range(0, 2));
			sm4_pkg::REG_DECRYPT: val[0] = 1'($urandom_range(0, 1));
			default: val = pick_word();
		endcase
		return val;
	endfunction

	always @(posedge clk) begin : check_results
		logic [127:0] want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (result_queue.size() == 0) begin
				$error("unexpected result %h_%h", result_high, result_low);
				err_cnt++;
			end else begin
				want = result_queue.pop_front();
				if (result_high !== want[127:64]) begin
					$error("result_high: expected %h, got %h", want[127:64], result_high);
					err_cnt++;
				end
				if (result_low !== want[63:0]) begin
					$error("result_low: expected %h, got %h", want[63:0], result_low);
					err_cnt++;
				end
			end
		end
	end

	// output side: random stall bursts, plus long hold-offs on request
	initial begin : drive_out_stall
		int stall_left;
		int cyc;
		stall_left = 0;
		cyc = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			cyc++;
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
				if (hold_req) begin
					hold_req = 0;
					stall_left = HOLD_CYCLES;
					holds_done++;
				end else if (!calm && (cyc / 256) % 3 != 2 && $urandom_range(0, 5) == 0) begin
					stall_left = $urandom_range(1, 14);
				end
			end
		end
	end

	initial begin : stimulus
		int directed_blocks;
		int msg_len;
		int holds_issued;
		int nwr;
		bit hold_msg;
		logic fb;
		logic [IW-1:0] idx;

		arst_n = 1'b0;
		in_valid = 1'b0;
		data_high = '0;
		data_low = '0;
		first_block = 1'b0;
		wr_en = 1'b0;
		wr_index = '0;
		wr_data = '0;
		cfg_key_hi = '0;
		cfg_key_lo = '0;
		cfg_iv_hi = '0;
		cfg_iv_lo = '0;
		cfg_mode = sm4_pkg::MODE_ECB;
		cfg_dec = 1'b0;
		chain_block = '0;
		keys_loaded = 0;
		for (int i = 0; i < NROUNDS; i++)
			round_keys[i] = '0;
		holds_issued = 0;

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		drive_idle(2);

		// standard vector, then the decrypt of its ciphertext
		wr_row(sm4_pkg::REG_KEY_HIGH, STD_HI);
		wr_row(sm4_pkg::REG_KEY_LOW, STD_LO);
		blk_row(STD_HI, STD_LO, 1'b1, 1, 64'h681e_df34_d206_965e, 64'h86b3_e94f_536e_4246);
		blk_row(64'd0, 64'd0, 1'b0);
		blk_row(ONES, ONES, 1'b0);
		wr_row(sm4_pkg::REG_DECRYPT, 64'd1);
		blk_row(64'h681e_df34_d206_965e, 64'h86b3_e94f_536e_4246, 1'b1, 1, STD_HI, STD_LO);
		blk_row(ONES, 64'd0, 1'b0);
		// CBC; direction flip and key change in mid-message
		wr_row(sm4_pkg::REG_CHAIN_MODE, {62'd0, sm4_pkg::MODE_CBC});
		wr_row(sm4_pkg::REG_DECRYPT, 64'd0);
		wr_row(sm4_pkg::REG_IV_HIGH, ONES);
		wr_row(sm4_pkg::REG_IV_LOW, 64'd0);
		blk_row(STD_HI, STD_LO, 1'b1);
		blk_row(ONES, ONES, 1'b0);
		blk_row(64'd0, 64'd0, 1'b0);
		wr_row(sm4_pkg::REG_DECRYPT, 64'd1);
		blk_row(64'ha5a5_a5a5_a5a5_a5a5, 64'h5a5a_5a5a_5a5a_5a5a, 1'b0);
		wr_row(sm4_pkg::REG_KEY_HIGH, ONES);
		wr_row(sm4_pkg::REG_IV_LOW, ONES);
		blk_row(64'h0f0f_0f0f_0f0f_0f0f, 64'hf0f0_f0f0_f0f0_f0f0, 1'b0);
		blk_row(STD_HI, STD_LO, 1'b1);
		blk_row(ONES, ONES, 1'b0);
		// CTR with the counter wrapping through all ones
		wr_row(sm4_pkg::REG_CHAIN_MODE, {62'd0, sm4_pkg::MODE_CTR});
		wr_row(sm4_pkg::REG_DECRYPT, 64'd0);
		wr_row(sm4_pkg::REG_IV_HIGH, ONES);
		wr_row(sm4_pkg::REG_IV_LOW, ONES - 64'd1);
		blk_row(64'd0, 64'd0, 1'b1);
		blk_row(ONES, ONES, 1'b0);
		blk_row(STD_HI, STD_LO, 1'b0);
		wr_row(sm4_pkg::REG_IV_HIGH, 64'd0);
		wr_row(sm4_pkg::REG_IV_LOW, ONES);
		wr_row(sm4_pkg::REG_DECRYPT, 64'd1);
		blk_row(64'd0, 64'd0, 1'b1);
		blk_row(ONES, 64'd0, 1'b0);
		// unused mode and unused register indexes
		wr_row(sm4_pkg::REG_CHAIN_MODE, {62'd0, MODE_SPARE});
		wr_row(REG_SPARE_A, ONES);
		wr_row(REG_SPARE_B, 64'h1234_5678_9abc_def0);
		blk_row(64'd0, ONES, 1'b0);
		blk_row(STD_HI, STD_LO, 1'b1);
		wr_row(sm4_pkg::REG_KEY_HIGH, 64'd0);
		wr_row(sm4_pkg::REG_KEY_LOW, 64'd0);
		wr_row(sm4_pkg::REG_CHAIN_MODE, {62'd0, sm4_pkg::MODE_ECB});
		wr_row(sm4_pkg::REG_DECRYPT, 64'd0);
		blk_row(64'd0, 64'd0, 1'b1);
		blk_row(ONES, ONES, 1'b0);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(directed_rows[i].idx, directed_rows[i].wdata);
			end else begin
				send_block(directed_rows[i].dh, directed_rows[i].dl, directed_rows[i].fb,
					directed_rows[i].fixed, directed_rows[i].eh, directed_rows[i].el);
			end
		end
		directed_blocks = blocks_sent;

		while (blocks_sent < directed_blocks + RANDOM_ITEMS) begin
			wait_idle();
			nwr = $urandom_range(0, 4);
			repeat (nwr) begin
				idx = IW'($urandom_range(0, 7));
				write_reg(idx, pick_reg_value(idx));
			end
			msg_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) :
				$urandom_range(1, 8);
			hold_msg = 0;
			if (holds_issued < 2 && blocks_sent >= directed_blocks + 120 + 140 * holds_issued)
					begin
				hold_req = 1;
				holds_issued++;
				hold_msg = 1;
				msg_len = 20;
			end
			for (int n = 0; n < msg_len; n++) begin
				fb = (n == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 24) == 0);
				if (!keys_loaded)
					fb = 1'b1;
				if (!calm && !hold_msg && ((blocks_sent / 32) % 3 != 2)
						&& $urandom_range(0, 4) == 0)
					drive_idle($urandom_range(1, 14));
				send_block(pick_word(), pick_word(), fb, 0, 64'd0, 64'd0);
			end
			if (blocks_sent >= directed_blocks + RANDOM_ITEMS - 60)
				calm = 1;
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("%0d blocks sent (%0d from the table), %0d results checked, %0d writes",
			blocks_sent, directed_blocks, results_seen, writes_done);
		$display("ECB, CBC and CTR in both directions, counter wrap, %0d long output holds",
			holds_done);
		if (err_cnt == 0 && result_queue.size() == 0)
			$display("sm4_cipher_ecb_cbc_ctr_top_tb passed");
		else
			$display("sm4_cipher_ecb_cbc_ctr_top_tb failed");
		$finish;
	end

endmodule
